FILE: hw/rtl/bounded_lifo_stack_top_assert.svh
// Assertion macros for the LIFO stack top level.
// Every check is sampled on the rising clock edge and is held off while reset is applied.
`ifndef BOUNDED_LIFO_STACK_TOP_ASSERT_SVH
`define BOUNDED_LIFO_STACK_TOP_ASSERT_SVH

// Same-cycle implication.
`define BLST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BLST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/blst_pkg.sv
package blst_pkg;

  // Number of cells in the stack.
  localparam int unsigned Depth = 16;
  // Entry count width: it must be able to hold Depth itself.
  localparam int unsigned CntW  = $clog2(Depth + 1);
  // Cell index width.
  localparam int unsigned IdxW  = $clog2(Depth);
  // Width of one stored word.
  localparam int unsigned DataW = 32;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } blst_cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } blst_status_e;

  // Shift control that is broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } blst_shift_t;

endpackage

FILE: hw/rtl/blst_cell.sv
module blst_cell import blst_pkg::*; (
  input  logic                    clk_i,
  input  blst_shift_t             shift_i,
  input  logic signed [DataW-1:0] upper_i,
  input  logic signed [DataW-1:0] lower_i,
  output logic signed [DataW-1:0] data_o
);

  logic signed [DataW-1:0] data_d, data_q;

  // On a push, take the word of the cell above; on a pop, take the one below.
  always_comb begin
    data_d = data_q;
    if (shift_i.push) begin
      data_d = upper_i;
    end else if (shift_i.pop) begin
      data_d = lower_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: hw/rtl/blst_chain.sv
module blst_chain import blst_pkg::*; (
  input  logic                    clk_i,
  input  blst_shift_t             shift_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic [IdxW-1:0]         peek_idx_i,
  output logic signed [DataW-1:0] top_o,
  output logic signed [DataW-1:0] peek_o
);

  logic signed [DataW-1:0] cell_q [Depth];

  // Cell 0 is the top of the stack; the word moves one cell per shift.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] upper, lower;

    if (i == 0) begin : g_first
      assign upper = push_value_i;
    end else begin : g_inner_up
      assign upper = cell_q[i-1];
    end

    // The bottom cell keeps its own word on a pop; it is no longer counted.
    if (i == Depth - 1) begin : g_last
      assign lower = cell_q[i];
    end else begin : g_inner_down
      assign lower = cell_q[i+1];
    end

    blst_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .upper_i(upper),
      .lower_i(lower),
      .data_o (cell_q[i])
    );
  end

  // The top word serves pop; peek selects one cell by position.
  assign top_o  = cell_q[0];
  assign peek_o = cell_q[peek_idx_i];

endmodule

FILE: hw/rtl/bounded_lifo_stack_top.sv
// Each result beat is registered when its command beat is accepted and appears in the following cycle.
// Throughput: one command per cycle while in_stall_o is low; the shifting cell row
// and the entry count are both updated in the cycle of acceptance.
// Reset: the entry count is cleared, capacity returns to 16 and the output is empty.
// Cell contents are not reset; only counted entries are ever read.
module bounded_lifo_stack_top import blst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CntW-1:0]         cfg_data_i,
  // Command channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              cmd_i,
  input  logic signed [DataW-1:0] push_value_i,
  input  logic [CntW-1:0]         position_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] read_data_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         entries_now_o,
  output logic                    is_empty_o,
  output logic                    is_full_o
);

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  logic [CntW-1:0] cap_q, cap_d;
  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  blst_shift_t     shift;
  logic signed [DataW-1:0] top_word, peek_word;
  logic [CntW-1:0] pos_m1;

  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] data_q, data_d;
  blst_status_e            status_q, status_d;
  logic [CntW-1:0]         entries_q;
  logic                    empty_q, full_q;

  logic                    push_ok, pop_ok;

  // A new command is taken unless a finished result is held by the consumer.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Capacity is clamped to 1..Depth when written.
  always_comb begin
    cap_d = cap_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        cap_d = OneCnt;
      end else if (cfg_data_i > DepthCnt) begin
        cap_d = DepthCnt;
      end else begin
        cap_d = cfg_data_i;
      end
    end
  end

  assign pos_m1 = position_i - OneCnt;

  // Command decode: shift control, new count and result fields.
  always_comb begin
    shift    = '0;
    count_d  = count_q;
    data_d   = '0;
    status_d = ST_OK;
    case (blst_cmd_e'(cmd_i))
      CMD_PUSH: begin
        if (count_q >= cap_q) begin
          status_d = ST_OVERFLOW;
        end else begin
          shift.push = accept;
          count_d    = count_q + OneCnt;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          status_d = ST_UNDERFLOW;
          data_d   = '1;
        end else begin
          shift.pop = accept;
          count_d   = count_q - OneCnt;
          data_d    = top_word;
        end
      end
      CMD_PEEK: begin
        if (position_i == '0 || position_i > count_q) begin
          status_d = ST_BADPOS;
          data_d   = '1;
        end else begin
          data_d = peek_word;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  blst_chain u_chain (
    .clk_i       (clk_i),
    .shift_i     (shift),
    .push_value_i(push_value_i),
    .peek_idx_i  (pos_m1[IdxW-1:0]),
    .top_o       (top_word),
    .peek_o      (peek_word)
  );

  // Output stage holds a result until the consumer takes it.
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= DepthCnt;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q    <= data_d;
      status_q  <= status_d;
      entries_q <= count_d;
      empty_q   <= (count_d == '0);
      full_q    <= (count_d >= cap_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = data_q;
  assign status_o      = status_q;
  assign entries_now_o = entries_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

  // Accepted push with room and accepted pop on a non-empty stack.
  assign push_ok = accept && (cmd_i == CMD_PUSH) && (count_q < cap_q);
  assign pop_ok  = accept && (cmd_i == CMD_POP) && (count_q != '0);

`include "bounded_lifo_stack_top_assert.svh"

  // The count never exceeds the number of cells.
  `BLST_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DepthCnt, "entry count above depth")
  // The capacity in effect always lies in 1..Depth.
  `BLST_ASSERT_NOW(a_cap_range, 1'b1, cap_q >= OneCnt && cap_q <= DepthCnt, "capacity out of range")
  // An accepted push with room raises the count by one.
  `BLST_ASSERT_NEXT(a_push_inc, push_ok, count_q == $past(count_q) + OneCnt, "bad push count")
  // An accepted pop on a non-empty stack lowers the count by one.
  `BLST_ASSERT_NEXT(a_pop_dec, pop_ok, count_q == $past(count_q) - OneCnt, "bad pop count")

endmodule

FILE: bench/bounded_lifo_stack_top_tb.sv
module bounded_lifo_stack_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blst_pkg::*;

  localparam logic [1:0]              CmdUnused = 2'd3;
  localparam logic signed [DataW-1:0] ErrWord   = -1;
  localparam int unsigned             LongHold  = 64;
  localparam int unsigned             MaxCycles = 400000;

  // One command beat as offered to the block.
  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [DataW-1:0] value;
    logic [CntW-1:0]         pos;
  } lifo_cmd_t;

  // One result beat as the block should report it.
  typedef struct packed {
    logic signed [DataW-1:0] data;
    blst_status_e            status;
    logic [CntW-1:0]         count;
    logic                    empty;
    logic                    full;
  } lifo_result_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [CntW-1:0]         cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              cmd_i        = CMD_PUSH;
  logic signed [DataW-1:0] push_value_i = '0;
  logic [CntW-1:0]         position_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic signed [DataW-1:0] read_data_o;
  logic [1:0]              status_o;
  logic [CntW-1:0]         entries_now_o;
  logic                    is_empty_o;
  logic                    is_full_o;

  bounded_lifo_stack_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .push_value_i (push_value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .status_o     (status_o),
    .entries_now_o(entries_now_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  initial forever #4 clk_i = ~clk_i;

  // Shadow copy of the stack and its capacity register.
  logic signed [DataW-1:0] shadow_cells [Depth];
  int unsigned             shadow_count = 0;
  logic [CntW-1:0]         shadow_cap   = 5'd16;

  lifo_cmd_t    pending_cmds [$];
  lifo_result_t expected_results [$];
  int unsigned  mismatches = 0;

  // Apply one command to the shadow stack and return the result it should give.
  function automatic lifo_result_t predict_lifo(logic [1:0] cmd, logic signed [DataW-1:0] value,
                                                logic [CntW-1:0] pos);
    lifo_result_t r;
    int unsigned  cap;
    cap = (shadow_cap == 0) ? 1 : (shadow_cap > Depth) ? Depth : shadow_cap;
    r.data   = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= cap) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_cells[shadow_count] = value;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_UNDERFLOW;
          r.data   = ErrWord;
        end else begin
          shadow_count--;
          r.data = shadow_cells[shadow_count];
        end
      end
      CMD_PEEK: begin
        if (pos == 0 || pos > shadow_count) begin
          r.status = ST_BADPOS;
          r.data   = ErrWord;
        end else begin
          r.data = shadow_cells[shadow_count - pos];
        end
      end
      default: ;
    endcase
    r.count = CntW'(shadow_count);
    r.empty = (shadow_count == 0);
    r.full  = (shadow_count >= cap);
    return r;
  endfunction

  // Idle stretch: mostly none, often short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [DataW-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Peek positions lean toward the valid range but cover the whole field.
  function automatic logic [CntW-1:0] rand_pos();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CntW'($urandom_range(17, 31));
    return CntW'($urandom_range(1, 16));
  endfunction

  function automatic lifo_cmd_t rand_item(int unsigned push_pct);
    lifo_cmd_t   it;
    int unsigned r;
    it.value = rand_word();
    it.pos   = rand_pos();
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      it.cmd = CMD_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      it.cmd = (r < 50) ? CMD_POP : (r < 95) ? CMD_PEEK : CmdUnused;
    end
    return it;
  endfunction

  task automatic add_cmd(logic [1:0] cmd, logic signed [DataW-1:0] value, logic [CntW-1:0] pos);
    lifo_cmd_t it;
    it.cmd   = cmd;
    it.value = value;
    it.pos   = pos;
    pending_cmds.push_back(it);
  endtask

  // Bursts with a changing push share so the fill level sweeps between empty and full.
  task automatic add_random(int unsigned n);
    int unsigned mix [4] = '{20, 50, 70, 90};
    int unsigned pct;
    pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 20 == 0) pct = mix[$urandom_range(0, 3)];
      pending_cmds.push_back(rand_item(pct));
    end
  endtask

  // Sampled mid-cycle so the check never races the clock edge.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CntW-1:0] cap);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_data_i <= cap;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Command driver: holds a beat until accepted, then idles for a random gap.
  int unsigned gap_left = 0;
  int unsigned drv_calm = 0;
  lifo_cmd_t   next_cmd;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      cmd_i        <= CMD_PUSH;
      push_value_i <= '0;
      position_i   <= '0;
      gap_left     <= 0;
      drv_calm     <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        next_cmd      = pending_cmds.pop_front();
        in_valid_i   <= 1'b1;
        cmd_i        <= next_cmd.cmd;
        push_value_i <= next_cmd.value;
        position_i   <= next_cmd.pos;
        if (drv_calm != 0) begin
          gap_left <= 0;
          drv_calm <= drv_calm - 1;
        end else begin
          gap_left <= idle_len();
          if ($urandom_range(0, 39) == 0) drv_calm <= $urandom_range(20, 80);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, calm stretches, and two long hold-offs that back up the block.
  int unsigned hold_left   = 0;
  int unsigned rx_calm     = 0;
  int unsigned beats_taken = 0;
  int unsigned holds_done  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      rx_calm     <= 0;
      beats_taken <= 0;
      holds_done  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) beats_taken <= beats_taken + 1;
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (holds_done < 2 && beats_taken >= 400 * (holds_done + 1)) begin
        out_stall_i <= 1'b1;
        hold_left   <= LongHold - 1;
        holds_done  <= holds_done + 1;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_calm != 0) begin
          rx_calm <= rx_calm - 1;
        end else begin
          hold_left <= idle_len();
          if ($urandom_range(0, 39) == 0) rx_calm <= $urandom_range(30, 120);
        end
      end
    end
  end

  task automatic check_field(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Monitor: tracks register writes, checks result beats, predicts each command beat.
  always @(posedge clk_i) begin : monitor_proc
    lifo_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) shadow_cap = cfg_data_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, data %0h status %0d", $time,
                   read_data_o, status_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.data, read_data_o);
          check_field("status", DataW'(want.status), DataW'(status_o));
          check_field("entries_now", DataW'(want.count), DataW'(entries_now_o));
          check_field("is_empty", DataW'(want.empty), DataW'(is_empty_o));
          check_field("is_full", DataW'(want.full), DataW'(is_full_o));
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(predict_lifo(cmd_i, push_value_i, position_i));
    end
  end

  // Watchdog.
  int unsigned cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == MaxCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [CntW-1:0] caps [8];
    caps = '{5'd31, 5'd16, 5'd1, 5'd2, 5'd9, 5'd0, 5'd16, CntW'($urandom_range(0, 31))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty-stack errors, word extremes, peek bounds and the unused command at reset capacity.
    add_cmd(CMD_POP, 32'sh0, 5'd0);
    add_cmd(CMD_PEEK, 32'sh0, 5'd0);
    add_cmd(CMD_PEEK, 32'sh0, 5'd1);
    add_cmd(CmdUnused, 32'sh0, 5'd0);
    add_cmd(CMD_PUSH, 32'sh7fffffff, 5'd0);
    add_cmd(CMD_PUSH, 32'sh80000000, 5'd0);
    add_cmd(CMD_PUSH, 32'sh0, 5'd0);
    add_cmd(CMD_PUSH, -1, 5'd0);
    add_cmd(CMD_PEEK, 32'sh0, 5'd1);
    add_cmd(CMD_PEEK, 32'sh0, 5'd4);
    add_cmd(CMD_PEEK, 32'sh0, 5'd5);
    add_cmd(CMD_PEEK, 32'sh0, 5'd0);
    add_cmd(CMD_PEEK, -1, 5'd31);
    add_cmd(CmdUnused, -1, 5'd31);
    repeat (5) add_cmd(CMD_POP, 32'sh0, 5'd0);

    // A capacity of zero acts as one: the second push overflows.
    write_capacity(5'd0);
    add_cmd(CMD_PUSH, 32'sh5a5a5a5a, 5'd0);
    add_cmd(CMD_PUSH, 32'sha5a5a5a5, 5'd0);
    add_cmd(CMD_PEEK, 32'sh0, 5'd1);
    add_cmd(CMD_POP, 32'sh0, 5'd0);
    add_cmd(CMD_POP, 32'sh0, 5'd0);

    // Random phases across capacity settings, the extremes among them.
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      add_random(110);
    end

    // Lower the capacity below the current fill level.
    write_capacity(5'd16);
    repeat (14) add_cmd(CMD_PUSH, rand_word(), rand_pos());
    write_capacity(5'd4);
    add_random(120);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/blst_pkg.sv
hw/rtl/blst_cell.sv
hw/rtl/blst_chain.sv
hw/rtl/bounded_lifo_stack_top.sv
bench/bounded_lifo_stack_top_tb.sv
